// File: rtl/rotation_matrix_to_rpy_angles_defines.svh
// Assertion macros for the rotation matrix to roll/pitch/yaw block.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef ROTATION_MATRIX_TO_RPY_ANGLES_DEFINES_SVH
`define ROTATION_MATRIX_TO_RPY_ANGLES_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define RPY_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the cycle after.
`define RPY_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rpy_pkg.sv
// Package for the rotation matrix to roll/pitch/yaw block.
// Holds item types, widths and the CORDIC arctangent table; depends on nothing.
`timescale 1ns / 1ps

package rpy_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int ELEM_W = 16;
    localparam int SQRT_N_W = 48;
    localparam int ATAN_IN_W = 26;
    localparam logic [15:0] HALF_PI_CODE = 16'h4000;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r10;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
        logic signed [15:0] r02;
        logic signed [15:0] r12;
    } in_t;

    typedef struct packed {
        logic signed [15:0] roll_a;
        logic signed [15:0] pitch_a;
        logic signed [15:0] yaw_a;
        logic signed [15:0] roll_b;
        logic signed [15:0] pitch_b;
        logic signed [15:0] yaw_b;
    } out_t;

    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] val;
        case (idx)
            0:  val = 32'd536870912;
            1:  val = 32'd316933406;
            2:  val = 32'd167458907;
            3:  val = 32'd85004756;
            4:  val = 32'd42667331;
            5:  val = 32'd21354465;
            6:  val = 32'd10679838;
            7:  val = 32'd5340245;
            8:  val = 32'd2670163;
            9:  val = 32'd1335087;
            10: val = 32'd667544;
            11: val = 32'd333772;
            12: val = 32'd166886;
            13: val = 32'd83443;
            14: val = 32'd41722;
            15: val = 32'd20861;
            16: val = 32'd10430;
            17: val = 32'd5215;
            18: val = 32'd2608;
            19: val = 32'd1304;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

// File: rtl/rpy_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module rpy_isqrt #(
    parameter int N_W = 48
) (
    input  logic                 clk,
    input  logic [N_W-1:0]       n_in,
    output logic [N_W/2-1:0]     root
);

    localparam int R_W = N_W / 2;
    localparam int REM_W = R_W + 4;

    logic [REM_W-1:0] rem_reg [0:R_W];
    logic [R_W-1:0]   root_reg [0:R_W];
    logic [N_W-1:0]   rest_reg [0:R_W];

    always_comb
    begin
        rem_reg[0] = '0;
        root_reg[0] = '0;
        rest_reg[0] = n_in;
    end

    for (genvar k = 0; k < R_W; k++) begin : g_stage
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;

        always_comb
        begin
            rem_sh = {rem_reg[k][REM_W-3:0], rest_reg[k][N_W-1:N_W-2]};
            trial = {{(REM_W-R_W-2){1'b0}}, root_reg[k], 2'b01};
        end

        always_ff @(posedge clk)
        begin
            rest_reg[k+1] <= {rest_reg[k][N_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg[k+1] <= rem_sh - trial;
                root_reg[k+1] <= {root_reg[k][R_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k+1] <= rem_sh;
                root_reg[k+1] <= {root_reg[k][R_W-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg[R_W];

endmodule

// File: rtl/rpy_cordic.sv
// Pipelined CORDIC atan2 in vectoring mode, one rotation per register stage.
// Depends on rpy_pkg for the arctangent table.
`timescale 1ns / 1ps

module rpy_cordic #(
    parameter int STEPS = rpy_pkg::CORDIC_STEPS,
    parameter int IN_W  = rpy_pkg::ATAN_IN_W
) (
    input  logic                   clk,
    input  logic signed [IN_W-1:0] y_in,
    input  logic signed [IN_W-1:0] x_in,
    output logic [15:0]            angle
);

    localparam int W = IN_W + 18;

    logic signed [W-1:0] x_reg [0:STEPS];
    logic signed [W-1:0] y_reg [0:STEPS];
    logic [31:0]         z_reg [0:STEPS];
    logic                zero_reg [0:STEPS];
    logic signed [W-1:0] x_ext;
    logic signed [W-1:0] y_ext;
    logic [31:0]         z_round;

    always_comb
    begin
        x_ext = {{(W-IN_W){x_in[IN_W-1]}}, x_in};
        y_ext = {{(W-IN_W){y_in[IN_W-1]}}, y_in};
    end

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (x_in == '0) && (y_in == '0);
        if (x_in[IN_W-1])
        begin
            x_reg[0] <= (-x_ext) <<< 14;
            y_reg[0] <= (-y_ext) <<< 14;
            z_reg[0] <= 32'h8000_0000;
        end
        else
        begin
            x_reg[0] <= x_ext <<< 14;
            y_reg[0] <= y_ext <<< 14;
            z_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic pos;

        assign pos = !y_reg[i][W-1] && (y_reg[i] != '0);

        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            if (pos)
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + rpy_pkg::atan_entry(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - rpy_pkg::atan_entry(i);
            end
        end
    end

    always_comb
    begin
        z_round = z_reg[STEPS] + 32'h0000_8000;
        angle = zero_reg[STEPS] ? 16'h0000 : z_round[31:16];
    end

endmodule

// File: rtl/rotation_matrix_to_rpy_angles.sv
// Throughput: one item per cycle; busy is always low.
// The path runs through the 24-stage square root and then the CORDIC stages.
// Reset clears only the valid bits; the datapath registers are not reset.
// Depends on rpy_pkg, rpy_isqrt, rpy_cordic and the assertion macro header.
`timescale 1ns / 1ps
`include "rotation_matrix_to_rpy_angles_defines.svh"

module rotation_matrix_to_rpy_angles #(
    parameter int CORDIC_STEPS = rpy_pkg::CORDIC_STEPS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rpy_pkg::in_t  operands,
    output logic          done,
    output rpy_pkg::out_t result
);

    localparam int N_W = rpy_pkg::SQRT_N_W;
    localparam int SQ = N_W / 2;
    localparam int AW = rpy_pkg::ATAN_IN_W;
    localparam int LAT = SQ + CORDIC_STEPS + 5;

    logic [LAT-1:0]       vld_reg;
    logic [LAT-1:0]       vld_next;
    rpy_pkg::in_t         in_reg;
    rpy_pkg::in_t         d1_reg;
    rpy_pkg::in_t         dly_reg [0:SQ];
    logic [31:0]          sq21_reg;
    logic [31:0]          sq22_reg;
    logic [31:0]          sum_reg;
    logic [SQ-1:0]        hyp;
    rpy_pkg::in_t         dd;
    logic signed [AW-1:0] hyp_s;
    logic signed [AW-1:0] num_s;
    logic [15:0]          ang [0:6];
    rpy_pkg::out_t        out_next;
    rpy_pkg::out_t        out_reg;

    function automatic logic signed [AW-1:0] ext(input logic signed [15:0] v);
        return {{(AW-16){v[15]}}, v};
    endfunction

    assign busy = 1'b0;

    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], start && !busy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg <= operands;
        d1_reg <= in_reg;
        dly_reg[0] <= d1_reg;
        sq21_reg <= 32'(in_reg.r21 * in_reg.r21);
        sq22_reg <= 32'(in_reg.r22 * in_reg.r22);
        sum_reg <= sq21_reg + sq22_reg;
    end

    for (genvar k = 0; k < SQ; k++) begin : g_dly
        always_ff @(posedge clk)
        begin
            dly_reg[k+1] <= dly_reg[k];
        end
    end

    rpy_isqrt #(.N_W(N_W)) u_isqrt (
        .clk  (clk),
        .n_in ({sum_reg, {(N_W-32){1'b0}}}),
        .root (hyp)
    );

    always_comb
    begin
        dd = dly_reg[SQ];
        hyp_s = {{(AW-SQ){1'b0}}, hyp};
        num_s = -(ext(dd.r20) <<< 8);
    end

    rpy_cordic #(.STEPS(CORDIC_STEPS), .IN_W(AW)) u_roll_a (
        .clk(clk), .y_in(ext(dd.r10)), .x_in(ext(dd.r00)), .angle(ang[0]));
    rpy_cordic #(.STEPS(CORDIC_STEPS), .IN_W(AW)) u_pitch_a (
        .clk(clk), .y_in(num_s), .x_in(hyp_s), .angle(ang[1]));
    rpy_cordic #(.STEPS(CORDIC_STEPS), .IN_W(AW)) u_yaw_a (
        .clk(clk), .y_in(ext(dd.r21)), .x_in(ext(dd.r22)), .angle(ang[2]));
    rpy_cordic #(.STEPS(CORDIC_STEPS), .IN_W(AW)) u_roll_b (
        .clk(clk), .y_in(-ext(dd.r10)), .x_in(-ext(dd.r00)), .angle(ang[3]));
    rpy_cordic #(.STEPS(CORDIC_STEPS), .IN_W(AW)) u_pitch_b (
        .clk(clk), .y_in(num_s), .x_in(-hyp_s), .angle(ang[4]));
    rpy_cordic #(.STEPS(CORDIC_STEPS), .IN_W(AW)) u_yaw_b (
        .clk(clk), .y_in(-ext(dd.r21)), .x_in(-ext(dd.r22)), .angle(ang[5]));
    rpy_cordic #(.STEPS(CORDIC_STEPS), .IN_W(AW)) u_roll_up (
        .clk(clk), .y_in(ext(dd.r12)), .x_in(ext(dd.r02)), .angle(ang[6]));

    always_comb
    begin
        out_next.pitch_a = ang[1];
        out_next.pitch_b = ang[4];
        if (ang[1] == rpy_pkg::HALF_PI_CODE)
        begin
            out_next.roll_a = ang[6];
            out_next.roll_b = ang[6];
            out_next.yaw_a = '0;
            out_next.yaw_b = '0;
        end
        else
        begin
            out_next.roll_a = ang[0];
            out_next.roll_b = ang[3];
            out_next.yaw_a = ang[2];
            out_next.yaw_b = ang[5];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done = vld_reg[LAT-1];
    assign result = out_reg;

    `RPY_ASSERT_SAME(a_done_from_start, done, $past(start, LAT), "done without a started item")
    `RPY_ASSERT_SAME(a_pitch_up_case,
        done && (result.pitch_a == rpy_pkg::HALF_PI_CODE),
        (result.yaw_a == '0) && (result.yaw_b == '0) && (result.roll_a == result.roll_b),
        "upward pitch case not applied")
    `RPY_ASSERT_NEXT(a_valid_moves, start, vld_reg[0], "accepted item lost its valid bit")

endmodule

// File: test/rotation_matrix_to_rpy_angles_checker.sv
// Checker for the rotation matrix to roll/pitch/yaw block: predicts both angle
// solutions of every accepted item and compares them with the results in order.
// Depends on rpy_pkg for the item types.
`timescale 1ns / 1ps

module rotation_matrix_to_rpy_angles_checker
    import rpy_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  in_t  operands,
    input  logic done,
    input  out_t result,
    output int   errors,
    output int   pending
);

    out_t angle_queue[$];

    localparam logic [31:0] ARCTAN_TABLE [20] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304
    };

    function automatic logic [15:0] binary_atan2(input longint y_in, input longint x_in);
        longint x;
        longint y;
        longint dx;
        longint dy;
        logic [31:0] z;
        x = x_in;
        y = y_in;
        z = 32'd0;
        if (x == 0 && y == 0)
            return 16'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        x = x * 16384;
        y = y * 16384;
        for (int i = 0; i < 20; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_TABLE[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_TABLE[i];
            end
        end
        z = z + 32'h8000;
        return z[31:16];
    endfunction

    function automatic longint floor_sqrt(input longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n)
            b = b >>> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic out_t predict_angles(input in_t m);
        out_t a;
        longint hyp;
        longint num;
        hyp = floor_sqrt((longint'(m.r21) * m.r21 + longint'(m.r22) * m.r22) * 65536);
        num = -longint'(m.r20) * 256;
        a.roll_a = binary_atan2(m.r10, m.r00);
        a.pitch_a = binary_atan2(num, hyp);
        a.yaw_a = binary_atan2(m.r21, m.r22);
        a.roll_b = binary_atan2(-longint'(m.r10), -longint'(m.r00));
        a.pitch_b = binary_atan2(num, -hyp);
        a.yaw_b = binary_atan2(-longint'(m.r21), -longint'(m.r22));
        if (a.pitch_a == HALF_PI_CODE)
        begin
            a.roll_a = binary_atan2(m.r12, m.r02);
            a.roll_b = a.roll_a;
            a.yaw_a = '0;
            a.yaw_b = '0;
        end
        return a;
    endfunction

    initial errors = 0;
    initial pending = 0;

    always @(posedge clk)
    begin
        out_t e;
        if (rst_n)
        begin
            if (done)
            begin
                if (angle_queue.size() == 0)
                begin
                    $error("Result with no item outstanding: %h", result);
                    errors <= errors + 1;
                end
                else
                begin
                    e = angle_queue.pop_front();
                    if (result.roll_a !== e.roll_a)
                        $error("roll_a expected %0d actual %0d", e.roll_a, result.roll_a);
                    if (result.pitch_a !== e.pitch_a)
                        $error("pitch_a expected %0d actual %0d", e.pitch_a, result.pitch_a);
                    if (result.yaw_a !== e.yaw_a)
                        $error("yaw_a expected %0d actual %0d", e.yaw_a, result.yaw_a);
                    if (result.roll_b !== e.roll_b)
                        $error("roll_b expected %0d actual %0d", e.roll_b, result.roll_b);
                    if (result.pitch_b !== e.pitch_b)
                        $error("pitch_b expected %0d actual %0d", e.pitch_b, result.pitch_b);
                    if (result.yaw_b !== e.yaw_b)
                        $error("yaw_b expected %0d actual %0d", e.yaw_b, result.yaw_b);
                    if (result !== e)
                        errors <= errors + 1;
                end
            end
            if (start && !busy)
                angle_queue = {angle_queue, predict_angles(operands)};
        end
        pending <= angle_queue.size();
    end

endmodule

// File: test/rotation_matrix_to_rpy_angles_test.sv
// Top of the rotation matrix to roll/pitch/yaw testbench: drives directed and
// random items with idle gaps. Depends on rpy_pkg, the block and the checker.
`timescale 1ns / 1ps

module rotation_matrix_to_rpy_angles_test;
    import rpy_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    in_t  operands = '0;
    logic done;
    out_t result;
    int   errors;
    int   pending;
    int   idle_pct;

    always #5 clk = ~clk;

    rotation_matrix_to_rpy_angles i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operands(operands), .done(done), .result(result)
    );

    rotation_matrix_to_rpy_angles_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .operands(operands),
        .done(done), .result(result), .errors(errors), .pending(pending)
    );

    function automatic logic [15:0] pick_element();
        case ($urandom_range(9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'd0;
            3: return 16'($urandom);
            4: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    task automatic send_item(input in_t m);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        operands <= m;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        in_t m;
        int s;
        idle_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_item('{16384, 0, 0, 0, 16384, 0, 0});
        send_item('{0, 0, 0, 0, 0, 0, 0});
        send_item('{-16384, 0, 0, 0, -16384, 0, 0});
        send_item('{0, 0, -16384, 0, 0, 16384, 0});
        send_item('{0, 0, -16384, 0, 0, 0, 16384});
        send_item('{0, 0, -16384, 0, 0, -11585, -11585});
        send_item('{0, 0, -16384, 0, 0, 0, 0});
        send_item('{0, 0, 16384, 0, 0, 16384, 0});
        send_item('{-16384, 0, 0, 0, 16384, 0, 0});
        send_item('{-16384, -1, 0, -1, -16384, 0, 0});
        send_item('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                    16'sh8000, 16'sh8000});
        send_item('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                    16'sh7fff, 16'sh7fff});
        send_item('{11585, 11585, 0, 11585, -11585, 0, 0});
        for (int n = 0; n < 1750; n++)
        begin
            idle_pct = (n < 440) ? 0 : (n < 880) ? 53 : (n < 1320) ? 0 : 29;
            if ($urandom_range(9) == 0)
            begin
                s = $urandom_range(1);
                m = '{pick_element(), pick_element(), s ? 16'sd16384 : -16'sd16384,
                      16'($signed($urandom_range(2)) - 1),
                      16'($signed($urandom_range(2)) - 1),
                      pick_element(), pick_element()};
            end
            else
                m = '{pick_element(), pick_element(), pick_element(), pick_element(),
                      pick_element(), pick_element(), pick_element()};
            send_item(m);
        end
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rpy_pkg.sv
rtl/rpy_isqrt.sv
rtl/rpy_cordic.sv
rtl/rotation_matrix_to_rpy_angles.sv
test/rotation_matrix_to_rpy_angles_checker.sv
test/rotation_matrix_to_rpy_angles_test.sv
